@@ hdl/mer_pkg.sv @@
// shared types and constants for the midi event renderer
// no dependencies; used by mer_route_map, the core and mer_checker
package mer_pkg;

	localparam int ROUTE_ID_BITS = 8;
	localparam int CH_ENTRY_BITS = 5 + ROUTE_ID_BITS;
	localparam int CT_ENTRY_BITS = 16 + ROUTE_ID_BITS;
	localparam int CFG_W = 52;
	localparam int CTL_REG_W = 48;
	localparam int CTL_TAB_W = 4 * CTL_REG_W;
	localparam int CACHE_AW = 11;
	localparam int CACHE_DEPTH = 2048;
	localparam int TRIG_W = 47;
	localparam int OFF_SLOTS = 5;

	localparam logic [2:0] OP_CTL = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_END = 3'd2;
	localparam logic [2:0] OP_RESET = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [2:0] KIND_CC = 3'd0;
	localparam logic [2:0] KIND_ON = 3'd1;
	localparam logic [2:0] KIND_OFF = 3'd2;
	localparam logic [2:0] KIND_ALL_OFF = 3'd3;
	localparam logic [2:0] KIND_ERR = 3'd4;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_NO_ROUTE = 2'd1;
	localparam logic [1:0] ERR_NO_PITCH = 2'd2;
	localparam logic [1:0] ERR_FULL = 2'd3;

	localparam logic [2:0] REG_DEF_CH = 3'd0;
	localparam logic [2:0] REG_CH_TAB = 3'd1;
	localparam logic [2:0] REG_CTL_A = 3'd2;
	localparam logic [2:0] REG_CTL_B = 3'd3;
	localparam logic [2:0] REG_CTL_C = 3'd4;
	localparam logic [2:0] REG_CTL_D = 3'd5;

	typedef struct packed {
		logic [4:0] ch;
		logic       ctl_hit;
		logic       split;
		logic [6:0] c1;
		logic [6:0] c2;
	} route_info_t;

	typedef struct packed {
		logic [OFF_SLOTS-1:0]      en;
		logic [OFF_SLOTS-1:0]      last;
		logic [OFF_SLOTS-1:0][4:0] ch;
		logic [4:0]                def_ch;
	} off_info_t;

endpackage

@@ hdl/mer_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies; holds the sent-value cache and the trigger slot table
module mer_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/mer_route_map.sv @@
// route lookups over the configuration registers: channel, control route,
// and the deduplicated all-notes-off channel list; uses mer_pkg
module mer_route_map #(
	parameter int CHANNEL_ROUTE_SLOTS = 4,
	parameter int CONTROL_ROUTE_SLOTS = 8
) (
	input  logic [mer_pkg::ROUTE_ID_BITS-1:0] route,
	input  logic [4:0]                        def_reg,
	input  logic [mer_pkg::CFG_W-1:0]         ch_tab,
	input  logic [mer_pkg::CTL_TAB_W-1:0]     ctl_tab,
	output mer_pkg::route_info_t              info,
	output mer_pkg::off_info_t                off
);

	localparam int CHE = mer_pkg::CH_ENTRY_BITS;
	localparam int CTE = mer_pkg::CT_ENTRY_BITS;
	localparam int RB = mer_pkg::ROUTE_ID_BITS;

	logic [4:0] dch;
	logic [3:0][4:0] ent_ch;
	logic [3:0] ent_vld;

	always_comb begin
		logic dup;
		logic later;
		if (def_reg == 5'd0) begin
			dch = 5'd1;
		end else if (def_reg > 5'd16) begin
			dch = 5'd16;
		end else begin
			dch = def_reg;
		end
		for (int i = 0; i < 4; i++) begin
			ent_ch[i] = {1'b0, ch_tab[i*CHE +: 4]} + 5'd1;
			ent_vld[i] = (i < CHANNEL_ROUTE_SLOTS) && ch_tab[i*CHE + 4 + RB];
		end

		// lowest matching entry wins, so walk downward
		info.ch = dch;
		for (int i = 3; i >= 0; i--) begin
			if (ent_vld[i] && ch_tab[i*CHE + 4 +: RB] == route) begin
				info.ch = ent_ch[i];
			end
		end

		info.ctl_hit = 1'b0;
		info.split = 1'b0;
		info.c1 = 7'd0;
		info.c2 = 7'd0;
		for (int i = CONTROL_ROUTE_SLOTS - 1; i >= 0; i--) begin
			if (ctl_tab[i*CTE + 15 + RB] && ctl_tab[i*CTE + 14 +: RB] == route) begin
				info.ctl_hit = 1'b1;
				info.split = ctl_tab[i*CTE + 14 + RB];
				info.c1 = ctl_tab[i*CTE + 7 +: 7];
				info.c2 = ctl_tab[i*CTE +: 7];
			end
		end

		// default channel first, then each new channel of the route table
		off.def_ch = dch;
		off.ch[0] = dch;
		off.en[0] = 1'b1;
		for (int i = 0; i < 4; i++) begin
			dup = (ent_ch[i] == dch);
			for (int j = 0; j < i; j++) begin
				if (ent_vld[j] && ent_ch[j] == ent_ch[i]) begin
					dup = 1'b1;
				end
			end
			off.ch[i+1] = ent_ch[i];
			off.en[i+1] = ent_vld[i] && !dup;
		end
		for (int k = 0; k < mer_pkg::OFF_SLOTS; k++) begin
			later = 1'b0;
			for (int m = k + 1; m < mer_pkg::OFF_SLOTS; m++) begin
				later = later | off.en[m];
			end
			off.last[k] = !later;
		end
	end

endmodule

@@ hdl/midi_event_renderer_core.sv @@
// Converts routed events into MIDI messages. A control point reads the cache for
// one or two controllers and then sends each message, a trigger start examines one
// slot a cycle until it finds a free one or reaches the last, and a trigger end
// reads and compares the slot table slot by slot; a stalled output holds their
// messages. The sent-value cache is a 2048-entry memory cleared by a sweep pass
// after reset, after every configuration write, and after a reset-outputs or
// silent-clear item; no item is taken during that pass. Results sit in an output
// register, so the next item is taken while the last result still waits.
// depends on mer_pkg, mer_ram, mer_route_map
module midi_event_renderer_core #(
	parameter int TRIGGER_SLOTS = 16,
	parameter int CHANNEL_ROUTE_SLOTS = 4,
	parameter int CONTROL_ROUTE_SLOTS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        opcode,
	input  logic [mer_pkg::ROUTE_ID_BITS-1:0] route_id,
	input  logic [15:0]                       voice_id,
	input  logic [15:0]                       trigger_id,
	input  logic signed [23:0]                amount,
	input  logic                              has_pitch,
	input  logic signed [23:0]                pitch,
	input  logic [15:0]                       frame_offset,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        message_kind,
	output logic [4:0]                        channel,
	output logic [6:0]                        first_data,
	output logic [6:0]                        second_data,
	output logic [15:0]                       timestamp,
	output logic [1:0]                        error_code,
	output logic                              last,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [mer_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int SLOT_BITS = TRIGGER_SLOTS > 1 ? $clog2(TRIGGER_SLOTS) : 1;
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TRIGGER_SLOTS - 1);
	localparam int CW = mer_pkg::CTL_REG_W;

	localparam logic [3:0] S_SWEEP = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DEC = 4'd2;
	localparam logic [3:0] S_CC1 = 4'd3;
	localparam logic [3:0] S_CC2 = 4'd4;
	localparam logic [3:0] S_CCDEC = 4'd5;
	localparam logic [3:0] S_EMIT1 = 4'd6;
	localparam logic [3:0] S_EMIT2 = 4'd7;
	localparam logic [3:0] S_FREE = 4'd8;
	localparam logic [3:0] S_END_RD = 4'd9;
	localparam logic [3:0] S_END_CHK = 4'd10;
	localparam logic [3:0] S_OFF = 4'd11;

	// configuration
	logic [4:0]                    def_ch_q;
	logic [mer_pkg::CFG_W-1:0]     ch_tab_q;
	logic [mer_pkg::CTL_TAB_W-1:0] ctl_tab_q;
	logic                          cfg_hit;

	// control
	logic [3:0]                      state_q;
	logic [mer_pkg::CACHE_AW-1:0]    sweep_cnt_q;
	logic [SLOT_BITS-1:0]            slot_cnt_q;
	logic [2:0]                      off_k_q;
	logic [TRIGGER_SLOTS-1:0]        active_q;

	// accepted item
	logic [2:0]                        op_q;
	logic [mer_pkg::ROUTE_ID_BITS-1:0] route_q;
	logic [15:0]                       voice_q;
	logic [15:0]                       trig_q;
	logic signed [23:0]                amt_q;
	logic                              hasp_q;
	logic signed [23:0]                pitch_q;
	logic [15:0]                       ts_q;
	logic signed [30:0]                prod_s1;

	// pending results
	logic [2:0] p1_kind_q;
	logic [6:0] p1_d1_q;
	logic [6:0] p1_d2_q;
	logic [1:0] p1_err_q;
	logic       e1_q;
	logic       cwr1_q;
	logic [6:0] p2_d1_q;
	logic [6:0] p2_d2_q;
	logic       e2_q;
	logic [7:0] want1_q;
	logic [7:0] want2_q;
	logic [7:0] data1_q;
	logic [mer_pkg::CACHE_AW-1:0] idx1_q;
	logic [mer_pkg::CACHE_AW-1:0] idx2_q;

	// output register
	logic       out_valid_q;
	logic [2:0] kind_q;
	logic [4:0] chan_q;
	logic [6:0] d1_q;
	logic [6:0] d2_q;
	logic [15:0] tstamp_q;
	logic [1:0] err_q;
	logic       last_q;

	mer_pkg::route_info_t info;
	mer_pkg::off_info_t   off;

	logic                         out_free;
	logic                         emit;
	logic [2:0]                   e_kind;
	logic [4:0]                   e_ch;
	logic [6:0]                   e_d1;
	logic [6:0]                   e_d2;
	logic [15:0]                  e_ts;
	logic [1:0]                   e_err;
	logic                         e_last;

	logic                         cache_we;
	logic [mer_pkg::CACHE_AW-1:0] cache_waddr;
	logic [7:0]                   cache_wdata;
	logic                         cache_re;
	logic [mer_pkg::CACHE_AW-1:0] cache_raddr;
	logic [7:0]                   cache_rdata;

	logic                         trig_we;
	logic                         trig_re;
	logic [mer_pkg::TRIG_W-1:0]   trig_wdata;
	logic [mer_pkg::TRIG_W-1:0]   trig_rdata;

	logic [4:0]                   ch_m1;
	logic [mer_pkg::CACHE_AW-1:0] idx1;
	logic [mer_pkg::CACHE_AW-1:0] idx2;
	logic [24:0]                  amt_sum;
	logic [16:0]                  amt_rnd;
	logic [24:0]                  pitch_sum;
	logic [16:0]                  pitch_rnd;
	logic [30:0]                  prod_sum;
	logic [22:0]                  vel_rnd;
	logic [6:0]                   note;
	logic [6:0]                   vel;
	logic [7:0]                   split_s;
	logic                         split_hi;
	logic [6:0]                   split_lo;
	logic [6:0]                   val127;
	logic [6:0]                   val1;
	logic [7:0]                   want1;
	logic [7:0]                   want2;
	logic [7:0]                   cached2;

	mer_route_map #(
		.CHANNEL_ROUTE_SLOTS(CHANNEL_ROUTE_SLOTS),
		.CONTROL_ROUTE_SLOTS(CONTROL_ROUTE_SLOTS)
	) u_route_map (
		.route  (route_q),
		.def_reg(def_ch_q),
		.ch_tab (ch_tab_q),
		.ctl_tab(ctl_tab_q),
		.info   (info),
		.off    (off)
	);

	mer_ram #(
		.WIDTH(8),
		.DEPTH(mer_pkg::CACHE_DEPTH)
	) u_cache (
		.clk  (clk),
		.we   (cache_we),
		.waddr(cache_waddr),
		.wdata(cache_wdata),
		.re   (cache_re),
		.raddr(cache_raddr),
		.rdata(cache_rdata)
	);

	mer_ram #(
		.WIDTH(mer_pkg::TRIG_W),
		.DEPTH(TRIGGER_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (trig_we),
		.waddr(slot_cnt_q),
		.wdata(trig_wdata),
		.re   (trig_re),
		.raddr(slot_cnt_q),
		.rdata(trig_rdata)
	);

	assign cfg_hit = cfg_we && (cfg_index <= mer_pkg::REG_CTL_D);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// value arithmetic: round half away from zero, negatives clamp to zero
	always_comb begin
		ch_m1 = info.ch - 5'd1;
		idx1 = {ch_m1[3:0], info.c1};
		idx2 = {ch_m1[3:0], info.c2};
		amt_sum = {amt_q[23], amt_q} + 25'd128;
		amt_rnd = amt_q[23] ? 17'd0 : amt_sum[24:8];
		pitch_sum = {pitch_q[23], pitch_q} + 25'd128;
		pitch_rnd = pitch_q[23] ? 17'd0 : pitch_sum[24:8];
		note = (pitch_rnd > 17'd127) ? 7'd127 : pitch_rnd[6:0];
		prod_sum = prod_s1 + 31'sd128;
		vel_rnd = prod_s1[30] ? 23'd0 : prod_sum[30:8];
		if (vel_rnd == 23'd0) begin
			vel = 7'd1;
		end else if (vel_rnd > 23'd127) begin
			vel = 7'd127;
		end else begin
			vel = vel_rnd[6:0];
		end
		val127 = (amt_rnd > 17'd127) ? 7'd127 : amt_rnd[6:0];
		split_s = (amt_rnd > 17'd199) ? 8'd199 : amt_rnd[7:0];
		split_hi = (split_s >= 8'd100);
		split_lo = split_hi ? 7'(split_s - 8'd100) : split_s[6:0];
		val1 = info.split ? {6'd0, split_hi} : val127;
		want1 = {1'b1, val1};
		want2 = {1'b1, split_lo};
		// both halves on one controller: the second sees the first's write
		cached2 = (idx1_q == idx2_q) ? want1 : cache_rdata;
	end

	always_comb begin
		emit = 1'b0;
		e_kind = mer_pkg::KIND_CC;
		e_ch = info.ch;
		e_d1 = 7'd0;
		e_d2 = 7'd0;
		e_ts = ts_q;
		e_err = mer_pkg::ERR_NONE;
		e_last = 1'b1;
		cache_we = 1'b0;
		cache_waddr = sweep_cnt_q;
		cache_wdata = 8'd0;
		cache_re = 1'b0;
		cache_raddr = idx1;
		trig_we = 1'b0;
		trig_re = 1'b0;
		trig_wdata = {voice_q, route_q, trig_q, note};
		case (state_q)
			S_SWEEP: begin
				cache_we = 1'b1;
			end
			S_CC1: begin
				cache_re = 1'b1;
			end
			S_CC2: begin
				cache_re = 1'b1;
				cache_raddr = idx2_q;
			end
			S_EMIT1: begin
				if (e1_q && out_free) begin
					emit = 1'b1;
					e_kind = p1_kind_q;
					e_d1 = p1_d1_q;
					e_d2 = p1_d2_q;
					e_err = p1_err_q;
					e_last = !e2_q;
					cache_we = cwr1_q;
					cache_waddr = idx1_q;
					cache_wdata = want1_q;
				end
			end
			S_EMIT2: begin
				if (e2_q && out_free) begin
					emit = 1'b1;
					e_d1 = p2_d1_q;
					e_d2 = p2_d2_q;
					cache_we = 1'b1;
					cache_waddr = idx2_q;
					cache_wdata = want2_q;
				end
			end
			S_FREE: begin
				trig_we = !active_q[slot_cnt_q];
			end
			S_END_RD: begin
				trig_re = 1'b1;
			end
			S_OFF: begin
				if (off.en[off_k_q] && out_free) begin
					emit = 1'b1;
					e_kind = mer_pkg::KIND_ALL_OFF;
					e_ch = off.ch[off_k_q];
					e_ts = 16'd0;
					e_last = off.last[off_k_q];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_ch_q <= 5'd1;
			ch_tab_q <= '0;
			ctl_tab_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mer_pkg::REG_DEF_CH: def_ch_q <= cfg_wdata[4:0];
				mer_pkg::REG_CH_TAB: ch_tab_q <= cfg_wdata;
				mer_pkg::REG_CTL_A: ctl_tab_q[0*CW +: CW] <= cfg_wdata[CW-1:0];
				mer_pkg::REG_CTL_B: ctl_tab_q[1*CW +: CW] <= cfg_wdata[CW-1:0];
				mer_pkg::REG_CTL_C: ctl_tab_q[2*CW +: CW] <= cfg_wdata[CW-1:0];
				mer_pkg::REG_CTL_D: ctl_tab_q[3*CW +: CW] <= cfg_wdata[CW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 31'(amt_q) * 31'sd127;
		if (state_q == S_IDLE && in_valid) begin
			op_q <= opcode;
			route_q <= route_id;
			voice_q <= voice_id;
			trig_q <= trigger_id;
			amt_q <= amount;
			hasp_q <= has_pitch;
			pitch_q <= pitch;
			ts_q <= frame_offset;
		end
		if (state_q == S_CC2) begin
			data1_q <= cache_rdata;
		end
		if (emit) begin
			kind_q <= e_kind;
			chan_q <= e_ch;
			d1_q <= e_d1;
			d2_q <= e_d2;
			tstamp_q <= e_ts;
			err_q <= e_err;
			last_q <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sweep_cnt_q <= '0;
			slot_cnt_q <= '0;
			off_k_q <= '0;
			active_q <= '0;
			e1_q <= 1'b0;
			e2_q <= 1'b0;
			cwr1_q <= 1'b0;
			p1_kind_q <= mer_pkg::KIND_CC;
			p1_d1_q <= '0;
			p1_d2_q <= '0;
			p1_err_q <= mer_pkg::ERR_NONE;
			p2_d1_q <= '0;
			p2_d2_q <= '0;
			want1_q <= '0;
			want2_q <= '0;
			idx1_q <= '0;
			idx2_q <= '0;
		end else begin
			case (state_q)
				S_SWEEP: begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
					if (&sweep_cnt_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					// error results share one pending slot
					p1_kind_q <= mer_pkg::KIND_ERR;
					p1_d1_q <= 7'd0;
					p1_d2_q <= 7'd0;
					e1_q <= 1'b1;
					e2_q <= 1'b0;
					cwr1_q <= 1'b0;
					slot_cnt_q <= '0;
					off_k_q <= '0;
					case (op_q)
						mer_pkg::OP_CTL: begin
							p1_err_q <= mer_pkg::ERR_NO_ROUTE;
							idx1_q <= idx1;
							idx2_q <= idx2;
							state_q <= info.ctl_hit ? S_CC1 : S_EMIT1;
						end
						mer_pkg::OP_START: begin
							p1_err_q <= mer_pkg::ERR_NO_PITCH;
							state_q <= hasp_q ? S_FREE : S_EMIT1;
						end
						mer_pkg::OP_END: begin
							state_q <= S_END_RD;
						end
						mer_pkg::OP_RESET: begin
							active_q <= '0;
							state_q <= S_OFF;
						end
						mer_pkg::OP_CLEAR: begin
							active_q <= '0;
							sweep_cnt_q <= '0;
							state_q <= S_SWEEP;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_CC1: begin
					state_q <= S_CC2;
				end
				S_CC2: begin
					state_q <= S_CCDEC;
				end
				S_CCDEC: begin
					p1_kind_q <= mer_pkg::KIND_CC;
					p1_d1_q <= info.c1;
					p1_d2_q <= val1;
					p1_err_q <= mer_pkg::ERR_NONE;
					p2_d1_q <= info.c2;
					p2_d2_q <= split_lo;
					want1_q <= want1;
					want2_q <= want2;
					cwr1_q <= 1'b1;
					e1_q <= (data1_q != want1);
					e2_q <= info.split && (cached2 != want2);
					state_q <= S_EMIT1;
				end
				S_EMIT1: begin
					if (!e1_q || out_free) begin
						state_q <= S_EMIT2;
					end
				end
				S_EMIT2: begin
					if (!e2_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FREE: begin
					if (!active_q[slot_cnt_q]) begin
						active_q[slot_cnt_q] <= 1'b1;
						p1_kind_q <= mer_pkg::KIND_ON;
						p1_d1_q <= note;
						p1_d2_q <= vel;
						p1_err_q <= mer_pkg::ERR_NONE;
						state_q <= S_EMIT1;
					end else if (slot_cnt_q == LAST_SLOT) begin
						p1_err_q <= mer_pkg::ERR_FULL;
						state_q <= S_EMIT1;
					end else begin
						slot_cnt_q <= slot_cnt_q + 1'b1;
					end
				end
				S_END_RD: begin
					state_q <= S_END_CHK;
				end
				S_END_CHK: begin
					if (active_q[slot_cnt_q] &&
					    trig_rdata[mer_pkg::TRIG_W-1:7] == {voice_q, route_q, trig_q}) begin
						active_q[slot_cnt_q] <= 1'b0;
						p1_kind_q <= mer_pkg::KIND_OFF;
						p1_d1_q <= trig_rdata[6:0];
						p1_d2_q <= 7'd0;
						p1_err_q <= mer_pkg::ERR_NONE;
						state_q <= S_EMIT1;
					end else if (slot_cnt_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end else begin
						slot_cnt_q <= slot_cnt_q + 1'b1;
						state_q <= S_END_RD;
					end
				end
				S_OFF: begin
					if (!off.en[off_k_q] || out_free) begin
						if (off_k_q == 3'(mer_pkg::OFF_SLOTS - 1)) begin
							sweep_cnt_q <= '0;
							state_q <= S_SWEEP;
						end else begin
							off_k_q <= off_k_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// any register write invalidates the whole cache
			if (cfg_hit) begin
				sweep_cnt_q <= '0;
				state_q <= S_SWEEP;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign message_kind = kind_q;
	assign channel = chan_q;
	assign first_data = d1_q;
	assign second_data = d2_q;
	assign timestamp = tstamp_q;
	assign error_code = err_q;
	assign last = last_q;

endmodule

@@ hdl/mer_checker.sv @@
// port-level checks for midi_event_renderer_core and the bind that attaches them
// depends on mer_pkg
module mer_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] message_kind,
	input logic [4:0] channel,
	input logic [6:0] first_data,
	input logic [6:0] second_data,
	input logic [15:0] timestamp,
	input logic [1:0] error_code
);

	// a stalled item keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(message_kind) &&
		$stable(channel) && $stable(first_data) && $stable(second_data))
		else $error("stalled result changed");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((message_kind == mer_pkg::KIND_ERR) ==
		(error_code != mer_pkg::ERR_NONE)))
		else $error("error code does not match message kind");

	a_all_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_kind == mer_pkg::KIND_ALL_OFF |->
		timestamp == 16'd0 && first_data == 7'd0 && second_data == 7'd0)
		else $error("all notes off carries data");

	a_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel >= 5'd1 && channel <= 5'd16)
		else $error("channel out of range");

	// an accepted item always occupies the block for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted back to back");

endmodule

bind midi_event_renderer_core mer_checker u_mer_checker (.*);

@@ tb/sv/tb_midi_event_renderer_core.sv @@
// self-checking testbench for midi_event_renderer_core: random and directed items,
// expected messages computed by a scoreboard class that models the block's state
// depends on mer_pkg and the core
module tb_midi_event_renderer_core;

	typedef struct {
		logic [2:0]         op;
		logic [7:0]         route;
		logic [15:0]        voice;
		logic [15:0]        trig;
		logic signed [23:0] amount;
		logic               has_pitch;
		logic signed [23:0] pitch;
		logic [15:0]        offset;
	} event_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  ch;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [15:0] ts;
		logic [1:0]  err;
		logic        last;
	} msg_t;

	class midi_scoreboard;
		logic [51:0] regs [6];
		logic [7:0]  sent [2048];
		logic        slot_on [16];
		logic [15:0] slot_voice [16];
		logic [7:0]  slot_route [16];
		logic [15:0] slot_trig [16];
		logic [6:0]  slot_note [16];
		msg_t        pending_msgs [$];
		int          errors;
		int          n_items;
		int          n_msgs;

		function void reset_state();
			foreach (regs[i]) regs[i] = '0;
			regs[mer_pkg::REG_DEF_CH] = 52'd1;
			clear_stores();
		endfunction

		function void clear_stores();
			foreach (sent[i]) sent[i] = '0;
			foreach (slot_on[i]) slot_on[i] = 1'b0;
		endfunction

		function void write_reg(int idx, logic [51:0] val);
			int w;
			w = (idx == mer_pkg::REG_DEF_CH) ? 5 : (idx == mer_pkg::REG_CH_TAB) ? 52 : 48;
			regs[idx] = val & ((52'd1 << w) - 52'd1);
			if (w == 52) regs[idx] = val;
			foreach (sent[i]) sent[i] = '0;
		endfunction

		function longint round8(longint x);
			if (x >= 0) return (x + 128) / 256;
			return -((-x + 128) / 256);
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function logic [4:0] def_ch();
			return 5'(clip(longint'(regs[mer_pkg::REG_DEF_CH]), 1, 16));
		endfunction

		function logic [4:0] route_channel(logic [7:0] route);
			for (int i = 0; i < 4; i++) begin
				if (regs[mer_pkg::REG_CH_TAB][13*i+12] &&
						regs[mer_pkg::REG_CH_TAB][13*i+4 +: 8] == route)
					return {1'b0, regs[mer_pkg::REG_CH_TAB][13*i +: 4]} + 5'd1;
			end
			return def_ch();
		endfunction

		function void push(logic [2:0] kind, logic [4:0] ch, logic [6:0] d1, logic [6:0] d2,
				logic [15:0] ts, logic [1:0] err);
			msg_t m;
			m = '{kind, ch, d1, d2, ts, err, 1'b0};
			pending_msgs.push_back(m);
		endfunction

		function void send_cc(logic [4:0] ch, logic [6:0] ctl, logic [6:0] val,
				logic [15:0] ts);
			logic [10:0] idx;
			idx = {ch[3:0] - 4'd1, ctl};
			if (sent[idx] == {1'b1, val}) return;
			sent[idx] = {1'b1, val};
			push(mer_pkg::KIND_CC, ch, ctl, val, ts, mer_pkg::ERR_NONE);
		endfunction

		function void note_input(event_t e);
			logic [4:0]  ch;
			logic [47:0] r;
			logic [23:0] ent;
			logic [16:0] done;
			int          found;
			int          n_prev;
			longint      v;
			ch = route_channel(e.route);
			n_prev = pending_msgs.size();
			found = -1;
			n_items++;
			case (e.op)
				mer_pkg::OP_CTL: begin
					for (int i = 0; i < 8 && found < 0; i++) begin
						r = regs[mer_pkg::REG_CTL_A + i/2][47:0];
						ent = r[(i%2)*24 +: 24];
						if (ent[23] && ent[21:14] == e.route) found = i;
					end
					if (found < 0) begin
						push(mer_pkg::KIND_ERR, ch, 7'd0, 7'd0, e.offset, mer_pkg::ERR_NO_ROUTE);
					end else begin
						r = regs[mer_pkg::REG_CTL_A + found/2][47:0];
						ent = r[(found%2)*24 +: 24];
						v = round8(longint'(e.amount));
						if (ent[22]) begin
							v = clip(v, 0, 199);
							send_cc(ch, ent[13:7], 7'(v / 100), e.offset);
							send_cc(ch, ent[6:0], 7'(v % 100), e.offset);
						end else begin
							send_cc(ch, ent[13:7], 7'(clip(v, 0, 127)), e.offset);
						end
					end
				end
				mer_pkg::OP_START: begin
					if (!e.has_pitch) begin
						push(mer_pkg::KIND_ERR, ch, 7'd0, 7'd0, e.offset, mer_pkg::ERR_NO_PITCH);
					end else begin
						for (int i = 0; i < 16 && found < 0; i++)
							if (!slot_on[i]) found = i;
						if (found < 0) begin
							push(mer_pkg::KIND_ERR, ch, 7'd0, 7'd0, e.offset, mer_pkg::ERR_FULL);
						end else begin
							slot_on[found] = 1'b1;
							slot_voice[found] = e.voice;
							slot_route[found] = e.route;
							slot_trig[found] = e.trig;
							slot_note[found] = 7'(clip(round8(longint'(e.pitch)), 0, 127));
							push(mer_pkg::KIND_ON, ch, slot_note[found],
								7'(clip(round8(longint'(e.amount) * 127), 1, 127)), e.offset,
								mer_pkg::ERR_NONE);
						end
					end
				end
				mer_pkg::OP_END: begin
					for (int i = 0; i < 16 && found < 0; i++) begin
						if (slot_on[i] && slot_voice[i] == e.voice && slot_route[i] == e.route
								&& slot_trig[i] == e.trig) begin
							found = i;
							slot_on[i] = 1'b0;
							push(mer_pkg::KIND_OFF, ch, slot_note[i], 7'd0, e.offset,
								mer_pkg::ERR_NONE);
						end
					end
				end
				mer_pkg::OP_RESET: begin
					clear_stores();
					done = '0;
					push(mer_pkg::KIND_ALL_OFF, def_ch(), 7'd0, 7'd0, 16'd0, mer_pkg::ERR_NONE);
					done[def_ch()] = 1'b1;
					for (int i = 0; i < 4; i++) begin
						if (regs[mer_pkg::REG_CH_TAB][13*i+12]) begin
							ch = {1'b0, regs[mer_pkg::REG_CH_TAB][13*i +: 4]} + 5'd1;
							if (!done[ch]) begin
								done[ch] = 1'b1;
								push(mer_pkg::KIND_ALL_OFF, ch, 7'd0, 7'd0, 16'd0,
									mer_pkg::ERR_NONE);
							end
						end
					end
				end
				mer_pkg::OP_CLEAR: clear_stores();
				default: ;
			endcase
			if (pending_msgs.size() > n_prev)
				pending_msgs[pending_msgs.size()-1].last = 1'b1;
		endfunction

		function void check_msg(msg_t got);
			msg_t want;
			n_msgs++;
			if (pending_msgs.size() == 0) begin
				$display("%0t: unexpected message kind=%0d ch=%0d d1=%0d d2=%0d", $time,
					got.kind, got.ch, got.d1, got.d2);
				errors++;
				return;
			end
			want = pending_msgs.pop_front();
			if (want !== got) begin
				$display("%0t: mismatch expected kind=%0d ch=%0d d1=%0d d2=%0d ts=%0d err=%0d last=%0d",
					$time, want.kind, want.ch, want.d1, want.d2, want.ts, want.err, want.last);
				$display("%0t:          actual kind=%0d ch=%0d d1=%0d d2=%0d ts=%0d err=%0d last=%0d",
					$time, got.kind, got.ch, got.d1, got.d2, got.ts, got.err, got.last);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         opcode = '0;
	logic [7:0]         route_id = '0;
	logic [15:0]        voice_id = '0;
	logic [15:0]        trigger_id = '0;
	logic signed [23:0] amount = '0;
	logic               has_pitch = 1'b0;
	logic signed [23:0] pitch = '0;
	logic [15:0]        frame_offset = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         message_kind;
	logic [4:0]         channel;
	logic [6:0]         first_data;
	logic [6:0]         second_data;
	logic [15:0]        timestamp;
	logic [1:0]         error_code;
	logic               last;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [51:0]        cfg_wdata = '0;

	midi_scoreboard sb;
	int             stall_left = 0;
	bit             calm = 0;
	event_t         started [$];

	midi_event_renderer_core dut (.*);

	always #5 clk = ~clk;

	// accepted items and messages are sampled at the edge that takes them
	always @(posedge clk) begin
		event_t e;
		msg_t m;
		if (arst_n && in_valid && !in_stall) begin
			e = '{opcode, route_id, voice_id, trigger_id, amount, has_pitch, pitch, frame_offset};
			sb.note_input(e);
		end
		if (arst_n && out_valid && !out_stall) begin
			m = '{message_kind, channel, first_data, second_data, timestamp, error_code, last};
			sb.check_msg(m);
		end
	end

	// receiver holds off a random number of cycles before each message
	always @(posedge clk) begin
		int n;
		if (out_valid && !out_stall || stall_left == 0 && !out_stall && !out_valid) begin
			n = calm ? 0 : $urandom_range(0, 6);
			stall_left <= n;
			out_stall <= (n != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end
	end

	task automatic send(event_t e);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= e.op;
		route_id <= e.route;
		voice_id <= e.voice;
		trigger_id <= e.trig;
		amount <= e.amount;
		has_pitch <= e.has_pitch;
		pitch <= e.pitch;
		frame_offset <= e.offset;
		do @(posedge clk); while (in_stall);
		if (e.op == mer_pkg::OP_START && e.has_pitch) started.push_back(e);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_msgs.size() != 0) @(posedge clk);
		// a trigger end with no match may still be searching the slot table
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [51:0] val);
		while (in_stall) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		// cache clearing pass follows every write
		repeat (4) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [12:0] ch_entry(bit v, logic [7:0] route, logic [3:0] ch0);
		return {v, route, ch0};
	endfunction

	function automatic logic [23:0] ctl_entry(bit v, bit split, logic [7:0] route,
			logic [6:0] c1, logic [6:0] c2);
		return {v, split, route, c1, c2};
	endfunction

	function automatic event_t ev(logic [2:0] op, logic [7:0] route, logic [15:0] voice,
			logic [15:0] trig, int amt, bit hp, int p, logic [15:0] ofs);
		event_t e;
		e = '{op, route, voice, trig, amt[23:0], hp, p[23:0], ofs};
		return e;
	endfunction

	task automatic write_all(logic [4:0] dc, logic [51:0] cht, logic [47:0] a,
			logic [47:0] b, logic [47:0] c, logic [47:0] d);
		drain();
		write_reg(mer_pkg::REG_DEF_CH, {47'd0, dc});
		write_reg(mer_pkg::REG_CH_TAB, cht);
		write_reg(mer_pkg::REG_CTL_A, {4'd0, a});
		write_reg(mer_pkg::REG_CTL_B, {4'd0, b});
		write_reg(mer_pkg::REG_CTL_C, {4'd0, c});
		write_reg(mer_pkg::REG_CTL_D, {4'd0, d});
	endtask

	task automatic random_config();
		logic [51:0] cht;
		logic [47:0] ct [4];
		for (int i = 0; i < 4; i++)
			cht[13*i +: 13] = ch_entry($urandom_range(0, 3) != 0, 8'($urandom_range(0, 7)),
				4'($urandom));
		for (int i = 0; i < 4; i++)
			ct[i] = {ctl_entry($urandom_range(0, 4) != 0, 1'($urandom),
				8'($urandom_range(0, 7)), 7'($urandom), 7'($urandom)),
				ctl_entry($urandom_range(0, 4) != 0, 1'($urandom),
				8'($urandom_range(0, 7)), 7'($urandom), 7'($urandom))};
		write_all(5'($urandom), cht, ct[0], ct[1], ct[2], ct[3]);
	endtask

	function automatic int rand_amount();
		int k;
		int frac;
		k = $urandom_range(0, 230) - 15;
		case ($urandom_range(0, 4))
			0: frac = 128;
			1: frac = -128;
			2: frac = 0;
			default: frac = $urandom_range(0, 255) - 128;
		endcase
		return ($urandom_range(0, 15) == 0) ? int'($urandom) : k * 256 + frac;
	endfunction

	task automatic random_item();
		event_t e;
		int     pick;
		e = ev(mer_pkg::OP_CTL, 8'($urandom_range(0, 9)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 3)), rand_amount(), $urandom_range(0, 9) != 0,
			rand_amount() - 20 * 256, 16'($urandom));
		if ($urandom_range(0, 19) == 0) begin
			e.route = 8'($urandom);
			e.voice = 16'($urandom);
			e.trig = 16'($urandom);
			e.pitch = 24'($urandom);
		end
		if ($urandom_range(0, 3) == 0) e.amount = 24'($urandom_range(0, 800) - 400);
		pick = $urandom_range(0, 99);
		if (pick < 40) e.op = mer_pkg::OP_CTL;
		else if (pick < 70) e.op = mer_pkg::OP_START;
		else if (pick < 93) begin
			e.op = mer_pkg::OP_END;
			if (started.size() != 0 && $urandom_range(0, 4) != 0) begin
				pick = $urandom_range(0, started.size() - 1);
				e.voice = started[pick].voice;
				e.route = started[pick].route;
				e.trig = started[pick].trig;
				started.delete(pick);
			end
		end else if (pick < 96) e.op = mer_pkg::OP_RESET;
		else if (pick < 98) e.op = mer_pkg::OP_CLEAR;
		else e.op = 3'($urandom_range(5, 7));
		send(e);
	endtask

	initial begin
		#50000000;
		$display("timeout");
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		sb = new();
		sb.reset_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		repeat (4) @(posedge clk);
		while (in_stall) @(posedge clk);

		// directed: with no routes every control point is an error on channel one
		send(ev(mer_pkg::OP_CTL, 8'd0, 0, 0, 256, 1, 0, 16'hffff));
		write_all(5'd16, {ch_entry(1, 8'd3, 4'd15), ch_entry(1, 8'd2, 4'd4),
			ch_entry(0, 8'd1, 4'd9), ch_entry(1, 8'd0, 4'd0)},
			{ctl_entry(1, 1, 8'd1, 7'd127, 7'd0), ctl_entry(1, 0, 8'd0, 7'd7, 7'd3)},
			{ctl_entry(1, 0, 8'd0, 7'd9, 7'd9), ctl_entry(1, 1, 8'd2, 7'd10, 7'd11)},
			{ctl_entry(0, 0, 8'd4, 7'd1, 7'd1), ctl_entry(1, 0, 8'd255, 7'd64, 7'd0)},
			'0);
		send(ev(mer_pkg::OP_CTL, 8'd0, 0, 0, 127 * 256, 1, 0, 1));
		send(ev(mer_pkg::OP_CTL, 8'd0, 0, 0, 127 * 256, 1, 0, 2));   // same value is suppressed
		send(ev(mer_pkg::OP_CTL, 8'd0, 0, 0, -8388608, 1, 0, 3));
		send(ev(mer_pkg::OP_CTL, 8'd0, 0, 0, 8388607, 1, 0, 4));
		send(ev(mer_pkg::OP_CTL, 8'd0, 0, 0, 384, 1, 0, 5));        // half rounds away from zero
		send(ev(mer_pkg::OP_CTL, 8'd1, 0, 0, 199 * 256, 1, 0, 6));  // split to hundreds and rest
		send(ev(mer_pkg::OP_CTL, 8'd2, 0, 0, 150 * 256 + 128, 1, 0, 7));
		send(ev(mer_pkg::OP_CTL, 8'd255, 0, 0, -128, 1, 0, 8));
		send(ev(mer_pkg::OP_CTL, 8'd4, 0, 0, 0, 1, 0, 9));
		send(ev(mer_pkg::OP_START, 8'd3, 16'hffff, 16'hffff, 0, 0, 0, 10));
		send(ev(mer_pkg::OP_START, 8'd3, 16'hffff, 16'hffff, -8388608, 1, 8388607, 11));
		send(ev(mer_pkg::OP_START, 8'd2, 16'h0000, 16'h0000, 8388607, 1, -8388608, 12));
		send(ev(mer_pkg::OP_START, 8'd7, 16'h5a5a, 16'ha5a5, 258, 1, 60 * 256 - 128, 13));
		send(ev(mer_pkg::OP_END, 8'd7, 16'h5a5a, 16'ha5a5, 0, 0, 0, 14));
		send(ev(mer_pkg::OP_END, 8'd7, 16'h5a5a, 16'ha5a5, 0, 0, 0, 15)); // already freed
		send(ev(mer_pkg::OP_RESET, 8'd0, 0, 0, 0, 0, 0, 16));
		send(ev(mer_pkg::OP_END, 8'd3, 16'hffff, 16'hffff, 0, 0, 0, 17)); // cleared by reset
		send(ev(mer_pkg::OP_START, 8'd1, 1, 1, 256, 1, 256, 18));
		send(ev(mer_pkg::OP_CLEAR, 8'd0, 0, 0, 0, 0, 0, 19));
		send(ev(mer_pkg::OP_END, 8'd1, 1, 1, 0, 0, 0, 20));
		send(ev(3'd5, 8'd0, 0, 0, 0, 1, 0, 21));
		send(ev(3'd7, 8'hff, 16'hffff, 16'hffff, -1, 1, -1, 16'hffff));
		started.delete();

		// out-of-range defaults clamp, and everything set to ones
		write_all(5'd0, '0, '1, '1, '1, '1);
		send(ev(mer_pkg::OP_RESET, 8'd0, 0, 0, 0, 0, 0, 0));
		send(ev(mer_pkg::OP_CTL, 8'hff, 0, 0, 1000, 1, 0, 1));
		write_all(5'd31, '1, '0, '0, '0, '0);
		send(ev(mer_pkg::OP_RESET, 8'd0, 0, 0, 0, 0, 0, 0));
		send(ev(mer_pkg::OP_CTL, 8'd0, 0, 0, 1000, 1, 0, 1));
		started.delete();

		for (int phase = 0; phase < 6; phase++) begin
			random_config();
			calm = (phase == 2);
			for (int n = 0; n < 62; n++) begin
				// a burst of starts now and then fills the slot table
				if (n == 30 && phase % 2 == 1) begin
					for (int k = 0; k < 18; k++)
						send(ev(mer_pkg::OP_START, 8'($urandom_range(0, 7)), 16'($urandom),
							16'($urandom), rand_amount(), 1, rand_amount(), 16'($urandom)));
				end
				random_item();
			end
			calm = 0;
		end

		drain();
		$display("%0d items taken, %0d messages checked over directed, clamped and six",
			sb.n_items, sb.n_msgs);
		$display("random register setups");
		if (sb.errors == 0 && sb.pending_msgs.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

@@ sim.f @@
hdl/mer_pkg.sv
hdl/mer_ram.sv
hdl/mer_route_map.sv
hdl/midi_event_renderer_core.sv
hdl/mer_checker.sv
tb/sv/tb_midi_event_renderer_core.sv
